/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define CTB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define CTB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/ctb_pkg.sv */
// Shared types, codes and sizes of the cursor text buffer.
// Used by the controller, the datapath, the top level and the checker.
package ctb_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int REQ_W    = 3;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 10;
    localparam int WORD_W   = 10;
    localparam int LEN_W    = 11;
    localparam int STAT_W   = 2;

    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT    = 3'd0,
        REQ_BACKSPACE = 3'd1,
        REQ_LEFT      = 3'd2,
        REQ_RIGHT     = 3'd3,
        REQ_READ      = 3'd4
    } req_code_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } st_code_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_FULL,
        OP_INS_INIT,
        OP_INS_RD,
        OP_INS_WR,
        OP_INS_PUT,
        OP_BS_INIT,
        OP_BS_RD,
        OP_BS_WR,
        OP_BS_END,
        OP_LEFT,
        OP_RIGHT,
        OP_RD_ISSUE,
        OP_RD_CAPTURE,
        OP_BAD_INDEX,
        OP_WALK_INIT,
        OP_WALK_STEP
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_CHECK,
        S_INS_WR,
        S_BS_CHECK,
        S_BS_WR,
        S_RD_CAP,
        S_WALK_INIT,
        S_WALK,
        S_RESULT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             full;
        logic             ep_zero;
        logic             ep_gt1;
        logic             right_ok;
        logic             idx_ok;
        logic             ptr_gt_ep;
        logic             ptr_lt_len;
        logic             walk_done;
    } dp_stat_t;

endpackage

/* rtl/core/ctb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/ctb_controller.sv */
// Request sequencer of the cursor text buffer.
// Depends on ctb_pkg; drives the datapath by command and reads its status.
module ctb_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  ctb_pkg::dp_stat_t  stat,
    output ctb_pkg::dp_cmd_t   cmd
);

    ctb_pkg::ctl_state_t state_reg;
    ctb_pkg::ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ctb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = ctb_pkg::OP_NONE;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ctb_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.op     = ctb_pkg::OP_LOAD;
                    state_next = ctb_pkg::S_DECODE;
                end
            end
            ctb_pkg::S_DECODE:
            begin
                state_next = ctb_pkg::S_WALK_INIT;
                case (stat.req)
                    ctb_pkg::REQ_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.op = ctb_pkg::OP_FULL;
                        end
                        else
                        begin
                            cmd.op     = ctb_pkg::OP_INS_INIT;
                            state_next = ctb_pkg::S_INS_CHECK;
                        end
                    end
                    ctb_pkg::REQ_BACKSPACE:
                    begin
                        if (!stat.ep_zero)
                        begin
                            cmd.op     = ctb_pkg::OP_BS_INIT;
                            state_next = ctb_pkg::S_BS_CHECK;
                        end
                    end
                    ctb_pkg::REQ_LEFT:
                    begin
                        if (stat.ep_gt1)
                        begin
                            cmd.op = ctb_pkg::OP_LEFT;
                        end
                    end
                    ctb_pkg::REQ_RIGHT:
                    begin
                        if (stat.right_ok)
                        begin
                            cmd.op = ctb_pkg::OP_RIGHT;
                        end
                    end
                    ctb_pkg::REQ_READ:
                    begin
                        if (stat.idx_ok)
                        begin
                            cmd.op     = ctb_pkg::OP_RD_ISSUE;
                            state_next = ctb_pkg::S_RD_CAP;
                        end
                        else
                        begin
                            cmd.op = ctb_pkg::OP_BAD_INDEX;
                        end
                    end
                    default:
                    begin
                        cmd.op = ctb_pkg::OP_NONE;
                    end
                endcase
            end
            ctb_pkg::S_INS_CHECK:
            begin
                if (stat.ptr_gt_ep)
                begin
                    cmd.op     = ctb_pkg::OP_INS_RD;
                    state_next = ctb_pkg::S_INS_WR;
                end
                else
                begin
                    cmd.op     = ctb_pkg::OP_INS_PUT;
                    state_next = ctb_pkg::S_WALK_INIT;
                end
            end
            ctb_pkg::S_INS_WR:
            begin
                cmd.op     = ctb_pkg::OP_INS_WR;
                state_next = ctb_pkg::S_INS_CHECK;
            end
            ctb_pkg::S_BS_CHECK:
            begin
                if (stat.ptr_lt_len)
                begin
                    cmd.op     = ctb_pkg::OP_BS_RD;
                    state_next = ctb_pkg::S_BS_WR;
                end
                else
                begin
                    cmd.op     = ctb_pkg::OP_BS_END;
                    state_next = ctb_pkg::S_WALK_INIT;
                end
            end
            ctb_pkg::S_BS_WR:
            begin
                cmd.op     = ctb_pkg::OP_BS_WR;
                state_next = ctb_pkg::S_BS_CHECK;
            end
            ctb_pkg::S_RD_CAP:
            begin
                cmd.op     = ctb_pkg::OP_RD_CAPTURE;
                state_next = ctb_pkg::S_WALK_INIT;
            end
            ctb_pkg::S_WALK_INIT:
            begin
                cmd.op     = ctb_pkg::OP_WALK_INIT;
                state_next = ctb_pkg::S_WALK;
            end
            ctb_pkg::S_WALK:
            begin
                if (stat.walk_done)
                begin
                    state_next = ctb_pkg::S_RESULT;
                end
                else
                begin
                    cmd.op = ctb_pkg::OP_WALK_STEP;
                end
            end
            ctb_pkg::S_RESULT:
            begin
                done       = 1'b1;
                state_next = ctb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ctb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/ctb_datapath.sv */
// Character store, length, cursor and word counter of the text buffer.
// Depends on ctb_pkg and ctb_ram; runs the commands of ctb_controller.
module ctb_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ctb_pkg::dp_cmd_t            cmd,
    output ctb_pkg::dp_stat_t           stat,
    input  logic [ctb_pkg::REQ_W-1:0]   req_type,
    input  logic [ctb_pkg::CHAR_W-1:0]  new_char,
    input  logic [ctb_pkg::IDX_W-1:0]   read_index,
    output logic [ctb_pkg::WORD_W-1:0]  word_tally,
    output logic [ctb_pkg::LEN_W-1:0]   text_length,
    output logic [ctb_pkg::LEN_W-1:0]   cursor_position,
    output logic [ctb_pkg::CHAR_W-1:0]  read_char,
    output logic [ctb_pkg::STAT_W-1:0]  status
);

    logic [ctb_pkg::REQ_W-1:0]  req_reg;
    logic [ctb_pkg::CHAR_W-1:0] ch_reg;
    logic [ctb_pkg::IDX_W-1:0]  idx_reg;
    logic [ctb_pkg::CNT_W-1:0]  len_reg;
    logic [ctb_pkg::CNT_W-1:0]  len_next;
    logic [ctb_pkg::CNT_W-1:0]  ep_reg;
    logic [ctb_pkg::CNT_W-1:0]  ep_next;
    logic [ctb_pkg::CNT_W-1:0]  ptr_reg;
    logic [ctb_pkg::CNT_W-1:0]  ptr_next;
    logic [ctb_pkg::CNT_W-1:0]  ptr_dec;
    logic [ctb_pkg::CNT_W-1:0]  words_reg;
    logic [ctb_pkg::CNT_W-1:0]  words_next;
    logic                       inside_reg;
    logic                       inside_next;
    logic                       pend_reg;
    logic                       pend_next;
    logic [ctb_pkg::CHAR_W-1:0] rchar_reg;
    logic [ctb_pkg::CHAR_W-1:0] rchar_next;
    logic [ctb_pkg::STAT_W-1:0] status_reg;
    logic [ctb_pkg::STAT_W-1:0] status_next;

    logic                        ram_we;
    logic [ctb_pkg::ADDR_W-1:0]  ram_waddr;
    logic [ctb_pkg::CHAR_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [ctb_pkg::ADDR_W-1:0]  ram_raddr;
    logic [ctb_pkg::CHAR_W-1:0]  ram_rdata;
    logic                        is_sep;

    ctb_ram #(
        .WIDTH (ctb_pkg::CHAR_W),
        .DEPTH (ctb_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ptr_dec = ptr_reg - ctb_pkg::CNT_W'(1);
    assign is_sep  = (ram_rdata == ctb_pkg::CH_SPACE) || (ram_rdata == ctb_pkg::CH_TAB)
                  || (ram_rdata == ctb_pkg::CH_NEWLINE);

    always_comb
    begin
        stat.req        = req_reg;
        stat.full       = (len_reg >= ctb_pkg::CNT_W'(ctb_pkg::CAPACITY));
        stat.ep_zero    = (ep_reg == '0);
        stat.ep_gt1     = (ep_reg > ctb_pkg::CNT_W'(1));
        stat.right_ok   = (ep_reg != '0) && (ep_reg < len_reg);
        stat.idx_ok     = (32'(idx_reg) < 32'(len_reg));
        stat.ptr_gt_ep  = (ptr_reg > ep_reg);
        stat.ptr_lt_len = (ptr_reg < len_reg);
        stat.walk_done  = !(ptr_reg < len_reg) && !pend_reg;
    end

    always_comb
    begin
        len_next    = len_reg;
        ep_next     = ep_reg;
        ptr_next    = ptr_reg;
        words_next  = words_reg;
        inside_next = inside_reg;
        pend_next   = pend_reg;
        rchar_next  = rchar_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = ptr_reg[ctb_pkg::ADDR_W-1:0];
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = ptr_reg[ctb_pkg::ADDR_W-1:0];
        case (cmd.op)
            ctb_pkg::OP_LOAD:
            begin
                rchar_next  = '0;
                status_next = ctb_pkg::ST_DONE;
            end
            ctb_pkg::OP_FULL:
            begin
                status_next = ctb_pkg::ST_FULL;
            end
            ctb_pkg::OP_INS_INIT:
            begin
                ptr_next = len_reg;
            end
            ctb_pkg::OP_INS_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = ptr_dec[ctb_pkg::ADDR_W-1:0];
            end
            ctb_pkg::OP_INS_WR:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_dec;
            end
            ctb_pkg::OP_INS_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = ep_reg[ctb_pkg::ADDR_W-1:0];
                ram_wdata = ch_reg;
                len_next  = len_reg + ctb_pkg::CNT_W'(1);
                ep_next   = ep_reg + ctb_pkg::CNT_W'(1);
            end
            ctb_pkg::OP_BS_INIT:
            begin
                ptr_next = ep_reg;
            end
            ctb_pkg::OP_BS_RD:
            begin
                ram_re = 1'b1;
            end
            ctb_pkg::OP_BS_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = ptr_dec[ctb_pkg::ADDR_W-1:0];
                ptr_next  = ptr_reg + ctb_pkg::CNT_W'(1);
            end
            ctb_pkg::OP_BS_END:
            begin
                len_next = len_reg - ctb_pkg::CNT_W'(1);
                ep_next  = ep_reg - ctb_pkg::CNT_W'(1);
            end
            ctb_pkg::OP_LEFT:
            begin
                ep_next = ep_reg - ctb_pkg::CNT_W'(1);
            end
            ctb_pkg::OP_RIGHT:
            begin
                ep_next = ep_reg + ctb_pkg::CNT_W'(1);
            end
            ctb_pkg::OP_RD_ISSUE:
            begin
                ram_re    = 1'b1;
                ram_raddr = ctb_pkg::ADDR_W'(idx_reg);
            end
            ctb_pkg::OP_RD_CAPTURE:
            begin
                rchar_next = ram_rdata;
            end
            ctb_pkg::OP_BAD_INDEX:
            begin
                status_next = ctb_pkg::ST_BAD_INDEX;
            end
            ctb_pkg::OP_WALK_INIT:
            begin
                ptr_next    = '0;
                words_next  = '0;
                inside_next = 1'b0;
                pend_next   = 1'b0;
            end
            ctb_pkg::OP_WALK_STEP:
            begin
                // Issue the next read while counting the byte fetched last cycle.
                if (ptr_reg < len_reg)
                begin
                    ram_re    = 1'b1;
                    ptr_next  = ptr_reg + ctb_pkg::CNT_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (is_sep)
                    begin
                        inside_next = 1'b0;
                    end
                    else
                    begin
                        if (!inside_reg)
                        begin
                            words_next = words_reg + ctb_pkg::CNT_W'(1);
                        end
                        inside_next = 1'b1;
                    end
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            ep_reg     <= '0;
            pend_reg   <= 1'b0;
            words_reg  <= '0;
            status_reg <= ctb_pkg::ST_DONE;
            rchar_reg  <= '0;
        end
        else
        begin
            len_reg    <= len_next;
            ep_reg     <= ep_next;
            pend_reg   <= pend_next;
            words_reg  <= words_next;
            status_reg <= status_next;
            rchar_reg  <= rchar_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == ctb_pkg::OP_LOAD)
        begin
            req_reg <= req_type;
            ch_reg  <= new_char;
            idx_reg <= read_index;
        end
        ptr_reg    <= ptr_next;
        inside_reg <= inside_next;
    end

    assign word_tally      = ctb_pkg::WORD_W'(words_reg);
    assign text_length     = ctb_pkg::LEN_W'(len_reg);
    assign cursor_position = ctb_pkg::LEN_W'(ep_reg);
    assign read_char       = rchar_reg;
    assign status          = status_reg;

endmodule

/* rtl/core/cursor_text_buffer.sv */
// Cursor text buffer: bounded byte store with an edit cursor and word count.
// A request runs in order: decode, then for an insert or a backspace a shift of
// the bytes after the cursor one byte at a time, or for a good read a fetch of
// the indexed byte, then a walk over the whole text that recounts the words.
// Then done rises; a new request is taken only once the block is idle again.
// Reset clears length and cursor at once; store undefined until written; no stall input.
module cursor_text_buffer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic [ctb_pkg::REQ_W-1:0]   req_type,
    input  logic [ctb_pkg::CHAR_W-1:0]  new_char,
    input  logic [ctb_pkg::IDX_W-1:0]   read_index,
    output logic [ctb_pkg::WORD_W-1:0]  word_tally,
    output logic [ctb_pkg::LEN_W-1:0]   text_length,
    output logic [ctb_pkg::LEN_W-1:0]   cursor_position,
    output logic [ctb_pkg::CHAR_W-1:0]  read_char,
    output logic [ctb_pkg::STAT_W-1:0]  status
);

    ctb_pkg::dp_cmd_t  cmd;
    ctb_pkg::dp_stat_t stat;

    ctb_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    ctb_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (req_type),
        .new_char        (new_char),
        .read_index      (read_index),
        .word_tally      (word_tally),
        .text_length     (text_length),
        .cursor_position (cursor_position),
        .read_char       (read_char),
        .status          (status)
    );

endmodule

/* rtl/core/ctb_checker.sv */
// Port-level checks of the cursor text buffer, bound to the top level.
// Depends on ctb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctb_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       done,
    input  logic [ctb_pkg::LEN_W-1:0]  text_length,
    input  logic [ctb_pkg::LEN_W-1:0]  cursor_position,
    input  logic [ctb_pkg::CHAR_W-1:0] read_char,
    input  logic [ctb_pkg::STAT_W-1:0] status
);

    `CTB_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |=> !busy && !done, "busy or done after reset")
    `CTB_ASSERT(a_start_busy, start && !busy |=> busy, "transfer not followed by busy")
    `CTB_ASSERT(a_done_single, done |-> busy ##1 !done, "result strobe longer than one cycle")
    `CTB_ASSERT(a_cursor_le_len, done |-> cursor_position <= text_length, "cursor beyond length")
    `CTB_ASSERT(a_bad_rd, done && status == ctb_pkg::ST_BAD_INDEX |-> read_char == '0, "bad read")

endmodule

bind cursor_text_buffer ctb_checker u_ctb_checker (.*);
